[rtl/core/bbtpc_pkg.sv]
// Shared types and constants for the bar/beat/tick position counter.
package bbtpc_pkg;

  // Field widths of the stream words
  localparam int unsigned BarW    = 16;
  localparam int unsigned BeatW   = 8;
  localparam int unsigned DivW    = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned InDataW  = BarW + BeatW + DivW + TickW;        // 48
  localparam int unsigned OutDataW = ((InDataW + 2 + 7) / 8) * 8;        // 56
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_CMP = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_DIV = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIVS_PER_BEAT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BEATS_PER_BAR = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_TICKS_PER_DIV = 16'd120;
  localparam logic [7:0]  RST_DIVS_PER_BEAT = 8'd4;
  localparam logic [7:0]  RST_BEATS_PER_BAR = 8'd4;

  // Operand position as it arrives on the input word
  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [DivW-1:0]  division;
    logic [BeatW-1:0] beat;
    logic [BarW-1:0]  bar;
  } opd_t;

  // Status flags of one step
  typedef struct packed {
    logic clamped;
    logic was_less;
  } flags_t;

endpackage

[rtl/core/bbtpc_step.sv]
// Combinational mixed-radix add / subtract / compare of the position.
module bbtpc_step #(
  parameter int unsigned BAR_WIDTH  = 16,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic [15:0]                 ticks_per_div_i,
  input  logic [7:0]                  divs_per_beat_i,
  input  logic [7:0]                  beats_per_bar_i,
  input  bbtpc_pkg::cmd_e             cmd_i,
  input  bbtpc_pkg::opd_t             opd_i,
  input  logic [BAR_WIDTH-1:0]        bar_i,
  input  logic [7:0]                  beat_i,
  input  logic [7:0]                  div_i,
  input  logic [TICK_WIDTH-1:0]       tick_i,
  output logic [BAR_WIDTH-1:0]        bar_o,
  output logic [7:0]                  beat_o,
  output logic [7:0]                  div_o,
  output logic [TICK_WIDTH-1:0]       tick_o,
  output bbtpc_pkg::flags_t           flags_o
);

  // Working widths: bar compare/add room, tick radix room
  localparam int unsigned OW  = ((BAR_WIDTH > 16) ? BAR_WIDTH : 16) + 1;
  localparam int unsigned TRW = ((TICK_WIDTH > 16) ? TICK_WIDTH : 16) + 1;
  localparam logic [TRW-1:0] TICK_LIM = TRW'(1) << TICK_WIDTH;
  localparam logic [OW-1:0]  BAR_MAX  = (OW'(1) << BAR_WIDTH) - OW'(1);

  // Effective radices
  logic [7:0]            rb, rd;
  logic [TRW-1:0]        rt_w;
  logic [TICK_WIDTH:0]   rt;

  // Clamped digits
  logic [TRW-1:0]        pt_w, ot_w;
  logic [TICK_WIDTH-1:0] pt, ot;
  logic [7:0]            pbt, obt, pdv, odv;
  logic [OW-1:0]         pb, ob;

  // Add chain
  logic [TICK_WIDTH:0]   ts;
  logic [8:0]            ds, bs;
  logic                  tc, dc, bc;
  logic [OW-1:0]         rs;

  // Subtract chain
  logic [TICK_WIDTH:0]   tn, tr;
  logic [8:0]            dn, dr, bn, br;
  logic                  tb, db, bb;
  logic [OW-1:0]         rn;

  logic                  less;

  // Radices; a zero register acts as one
  always_comb begin
    rb   = (beats_per_bar_i == 8'd0) ? 8'd1 : beats_per_bar_i;
    rd   = (divs_per_beat_i == 8'd0) ? 8'd1 : divs_per_beat_i;
    rt_w = (ticks_per_div_i == 16'd0) ? TRW'(1) :
           ((TRW'(ticks_per_div_i) > TICK_LIM) ? TICK_LIM : TRW'(ticks_per_div_i));
    rt   = rt_w[TICK_WIDTH:0];
  end

  // Digit clamping to radix minus one
  always_comb begin
    pt_w = (TRW'(tick_i) >= rt_w) ? rt_w - TRW'(1) : TRW'(tick_i);
    ot_w = (TRW'(opd_i.tick) >= rt_w) ? rt_w - TRW'(1) : TRW'(opd_i.tick);
    pt   = pt_w[TICK_WIDTH-1:0];
    ot   = ot_w[TICK_WIDTH-1:0];
    pdv  = (div_i >= rd) ? rd - 8'd1 : div_i;
    odv  = (opd_i.division >= rd) ? rd - 8'd1 : opd_i.division;
    pbt  = (beat_i >= rb) ? rb - 8'd1 : beat_i;
    obt  = (opd_i.beat >= rb) ? rb - 8'd1 : opd_i.beat;
    pb   = OW'(bar_i);
    ob   = OW'(opd_i.bar);
  end

  // Old position below operand, bar digit first
  always_comb begin
    less = (pb < ob) ||
           ((pb == ob) && ((pbt < obt) ||
           ((pbt == obt) && ((pdv < odv) ||
           ((pdv == odv) && (pt < ot))))));
  end

  // Add with carry, wrap at each radix, saturate bar
  always_comb begin
    ts = {1'b0, pt} + {1'b0, ot};
    tc = (ts >= rt);
    if (tc) begin
      ts = ts - rt;
    end
    ds = {1'b0, pdv} + {1'b0, odv} + {8'd0, tc};
    dc = (ds >= {1'b0, rd});
    if (dc) begin
      ds = ds - {1'b0, rd};
    end
    bs = {1'b0, pbt} + {1'b0, obt} + {8'd0, dc};
    bc = (bs >= {1'b0, rb});
    if (bc) begin
      bs = bs - {1'b0, rb};
    end
    rs = pb + ob + OW'(bc);
  end

  // Subtract with borrow
  always_comb begin
    tn = {1'b0, ot};
    tb = (tn > {1'b0, pt});
    tr = tb ? ({1'b0, pt} + rt - tn) : ({1'b0, pt} - tn);
    dn = {1'b0, odv} + {8'd0, tb};
    db = (dn > {1'b0, pdv});
    dr = db ? ({1'b0, pdv} + {1'b0, rd} - dn) : ({1'b0, pdv} - dn);
    bn = {1'b0, obt} + {8'd0, db};
    bb = (bn > {1'b0, pbt});
    br = bb ? ({1'b0, pbt} + {1'b0, rb} - bn) : ({1'b0, pbt} - bn);
    rn = ob + OW'(bb);
  end

  // Command select; clamped digits are written back on compare too
  always_comb begin
    bar_o            = pb[BAR_WIDTH-1:0];
    beat_o           = pbt;
    div_o            = pdv;
    tick_o           = pt;
    flags_o.was_less = less;
    flags_o.clamped  = 1'b0;
    unique case (cmd_i)
      bbtpc_pkg::CMD_ADD: begin
        beat_o = bs[7:0];
        div_o  = ds[7:0];
        tick_o = ts[TICK_WIDTH-1:0];
        if (rs > BAR_MAX) begin
          bar_o           = BAR_MAX[BAR_WIDTH-1:0];
          flags_o.clamped = 1'b1;
        end else begin
          bar_o = rs[BAR_WIDTH-1:0];
        end
      end
      bbtpc_pkg::CMD_SUB: begin
        if (less) begin
          bar_o           = '0;
          beat_o          = '0;
          div_o           = '0;
          tick_o          = '0;
          flags_o.clamped = 1'b1;
        end else begin
          bar_o  = (rn > pb) ? '0 : BAR_WIDTH'(pb - rn);
          beat_o = br[7:0];
          div_o  = dr[7:0];
          tick_o = tr[TICK_WIDTH-1:0];
        end
      end
      default: begin
        // compare and unused code keep the position
      end
    endcase
  end

endmodule

[rtl/core/bar_beat_tick_position_counter.sv]
// Top level of the bar/beat/division/tick position counter.
//
//  port group  dir  width  word contents (low bit first)
//  s_axis      in   48+2   tdata: operand bar, beat, division, tick; tuser: cmd
//  m_axis      out  56     tdata: bar, beat, division, tick, was_less, clamped
//  cfg         in   16     index 0 tick radix, 1 division radix, 2 beat radix
//
// One word per cycle sustained while m_axis is ready. A word waits in the input
// register until the output register is free; then the four-digit carry chain
// updates the position and loads the output register, raising tvalid, at the same edge.
// Reset clears the position and loads the default radices (120, 4, 4).
// A stall on m_axis holds the output word; the input register still takes a
// new word whenever it moves into the output register in the same cycle.
module bar_beat_tick_position_counter #(
  parameter int unsigned BAR_WIDTH  = 16,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // operand_bar, operand_beat, operand_division, operand_tick
  input  logic [bbtpc_pkg::InDataW-1:0]      s_axis_tdata,
  // cmd
  input  logic [bbtpc_pkg::CmdW-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pos_bar, pos_beat, pos_division, pos_tick, was_less, clamped, zero pad
  output logic [bbtpc_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [bbtpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bbtpc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned OW  = ((BAR_WIDTH > 16) ? BAR_WIDTH : 16);
  localparam int unsigned TRW = ((TICK_WIDTH > 16) ? TICK_WIDTH : 16);

  // Configuration registers
  logic [15:0] tpd_q;
  logic [7:0]  dpb_q, bpb_q;

  // Input register
  logic                  in_valid_q, in_valid_d;
  bbtpc_pkg::cmd_e       in_cmd_q;
  bbtpc_pkg::opd_t       in_opd_q;

  // Position state
  logic [BAR_WIDTH-1:0]  bar_q, bar_d;
  logic [7:0]            beat_q, beat_d;
  logic [7:0]            div_q, div_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  bbtpc_pkg::flags_t     flags;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [bbtpc_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic s_fire, advance, m_fire;
  logic [OW-1:0]  bar_ext;
  logic [TRW-1:0] tick_ext;

  // Handshake
  assign m_fire        = out_valid_q && m_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpd_q <= bbtpc_pkg::RST_TICKS_PER_DIV;
      dpb_q <= bbtpc_pkg::RST_DIVS_PER_BEAT;
      bpb_q <= bbtpc_pkg::RST_BEATS_PER_BAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbtpc_pkg::CFG_TICKS_PER_DIV: tpd_q <= cfg_wdata_i;
        bbtpc_pkg::CFG_DIVS_PER_BEAT: dpb_q <= cfg_wdata_i[7:0];
        bbtpc_pkg::CFG_BEATS_PER_BAR: bpb_q <= cfg_wdata_i[7:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q <= bbtpc_pkg::cmd_e'(s_axis_tuser);
      in_opd_q <= bbtpc_pkg::opd_t'(s_axis_tdata);
    end
  end

  // Position arithmetic
  bbtpc_step #(
    .BAR_WIDTH  (BAR_WIDTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_step (
    .ticks_per_div_i (tpd_q),
    .divs_per_beat_i (dpb_q),
    .beats_per_bar_i (bpb_q),
    .cmd_i           (in_cmd_q),
    .opd_i           (in_opd_q),
    .bar_i           (bar_q),
    .beat_i          (beat_q),
    .div_i           (div_q),
    .tick_i          (tick_q),
    .bar_o           (bar_d),
    .beat_o          (beat_d),
    .div_o           (div_d),
    .tick_o          (tick_d),
    .flags_o         (flags)
  );

  // Position state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q  <= '0;
      beat_q <= '0;
      div_q  <= '0;
      tick_q <= '0;
    end else if (advance) begin
      bar_q  <= bar_d;
      beat_q <= beat_d;
      div_q  <= div_d;
      tick_q <= tick_d;
    end
  end

  // Result word
  always_comb begin
    bar_ext    = OW'(bar_d);
    tick_ext   = TRW'(tick_d);
    out_data_d = bbtpc_pkg::OutDataW'({flags.clamped, flags.was_less, tick_ext[15:0],
                                       div_d, beat_d, bar_ext[15:0]});
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

[dv/bbtpc_position_checker.sv]
// Scoreboard for the bar/beat/division/tick counter: predicts each position word and compares.
module bbtpc_position_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // operand side
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [bbtpc_pkg::InDataW-1:0]  in_data_i,
  input  logic [bbtpc_pkg::CmdW-1:0]     in_cmd_i,
  // position side
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [bbtpc_pkg::OutDataW-1:0] out_data_i,
  // radix writes
  input  logic                           cfg_we_i,
  input  logic [bbtpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bbtpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o
);

  localparam int unsigned BarW  = bbtpc_pkg::BarW;
  localparam int unsigned BeatW = bbtpc_pkg::BeatW;
  localparam int unsigned DivW  = bbtpc_pkg::DivW;
  localparam int unsigned TickW = bbtpc_pkg::TickW;

  // Position word as it leaves the block, low field in the low bits
  typedef struct packed {
    logic             clamped;
    logic             was_less;
    logic [TickW-1:0] tick;
    logic [DivW-1:0]  division;
    logic [BeatW-1:0] beat;
    logic [BarW-1:0]  bar;
  } pos_word_t;

  localparam int unsigned WordW = $bits(pos_word_t);

  // Predicted position and radix registers
  logic [BarW-1:0]  bar_cnt;
  logic [BeatW-1:0] beat_cnt;
  logic [DivW-1:0]  div_cnt;
  logic [TickW-1:0] tick_cnt;
  logic [15:0]      tick_radix_reg;
  logic [7:0]       div_radix_reg;
  logic [7:0]       beat_radix_reg;

  pos_word_t expected_positions[$];
  pos_word_t want_word;
  pos_word_t got_word;
  int        err_count;
  int        results_seen;

  // Apply one command to the predicted position; returns the expected word
  function automatic pos_word_t advance_position(logic [bbtpc_pkg::CmdW-1:0] cmd,
                                                 bbtpc_pkg::opd_t opd);
    logic [TickW:0]   r_tick;
    logic [DivW:0]    r_div;
    logic [BeatW:0]   r_beat;
    logic [BarW-1:0]  p_bar, o_bar;
    logic [BeatW-1:0] p_beat, o_beat;
    logic [DivW-1:0]  p_div, o_div;
    logic [TickW-1:0] p_tick, o_tick;
    logic [TickW+1:0] t_acc;
    logic [DivW+1:0]  d_acc;
    logic [BeatW+1:0] b_acc;
    logic [BarW:0]    bar_acc;
    logic             carry;
    pos_word_t        w;

    // zero register acts as radix one
    r_tick = (tick_radix_reg == '0) ? {{TickW{1'b0}}, 1'b1} : {1'b0, tick_radix_reg};
    r_div  = (div_radix_reg == '0) ? {{DivW{1'b0}}, 1'b1} : {1'b0, div_radix_reg};
    r_beat = (beat_radix_reg == '0) ? {{BeatW{1'b0}}, 1'b1} : {1'b0, beat_radix_reg};

    // digits at or above their radix are pulled down to radix minus one
    p_bar  = bar_cnt;
    o_bar  = opd.bar;
    p_beat = (beat_cnt >= r_beat) ? BeatW'(r_beat - 1) : beat_cnt;
    o_beat = (opd.beat >= r_beat) ? BeatW'(r_beat - 1) : opd.beat;
    p_div  = (div_cnt >= r_div) ? DivW'(r_div - 1) : div_cnt;
    o_div  = (opd.division >= r_div) ? DivW'(r_div - 1) : opd.division;
    p_tick = (tick_cnt >= r_tick) ? TickW'(r_tick - 1) : tick_cnt;
    o_tick = (opd.tick >= r_tick) ? TickW'(r_tick - 1) : opd.tick;

    w.was_less = ({p_bar, p_beat, p_div, p_tick} < {o_bar, o_beat, o_div, o_tick});
    w.clamped  = 1'b0;
    w.bar      = p_bar;
    w.beat     = p_beat;
    w.division = p_div;
    w.tick     = p_tick;

    case (cmd)
      bbtpc_pkg::CMD_ADD: begin
        carry = 1'b0;
        t_acc = p_tick + o_tick;
        if (t_acc >= r_tick) begin
          t_acc = t_acc - r_tick;
          carry = 1'b1;
        end
        w.tick = t_acc[TickW-1:0];
        d_acc = p_div + o_div + carry;
        carry = 1'b0;
        if (d_acc >= r_div) begin
          d_acc = d_acc - r_div;
          carry = 1'b1;
        end
        w.division = d_acc[DivW-1:0];
        b_acc = p_beat + o_beat + carry;
        carry = 1'b0;
        if (b_acc >= r_beat) begin
          b_acc = b_acc - r_beat;
          carry = 1'b1;
        end
        w.beat = b_acc[BeatW-1:0];
        // bar saturates, lower digits keep their wrapped values
        bar_acc = p_bar + o_bar + carry;
        if (bar_acc[BarW]) begin
          w.bar     = '1;
          w.clamped = 1'b1;
        end else begin
          w.bar = bar_acc[BarW-1:0];
        end
      end
      bbtpc_pkg::CMD_SUB: begin
        if (w.was_less) begin
          // floor at zero
          w.bar      = '0;
          w.beat     = '0;
          w.division = '0;
          w.tick     = '0;
          w.clamped  = 1'b1;
        end else begin
          t_acc = o_tick;
          if (t_acc > p_tick) begin
            w.tick = TickW'(p_tick + r_tick - t_acc);
            carry  = 1'b1;
          end else begin
            w.tick = TickW'(p_tick - t_acc);
            carry  = 1'b0;
          end
          d_acc = o_div + carry;
          if (d_acc > p_div) begin
            w.division = DivW'(p_div + r_div - d_acc);
            carry      = 1'b1;
          end else begin
            w.division = DivW'(p_div - d_acc);
            carry      = 1'b0;
          end
          b_acc = o_beat + carry;
          if (b_acc > p_beat) begin
            w.beat = BeatW'(p_beat + r_beat - b_acc);
            carry  = 1'b1;
          end else begin
            w.beat = BeatW'(p_beat - b_acc);
            carry  = 1'b0;
          end
          bar_acc = o_bar + carry;
          w.bar   = (bar_acc > p_bar) ? '0 : BarW'(p_bar - bar_acc);
        end
      end
      default: begin
        // compare and the unused code leave the clamped position as is
      end
    endcase

    // clamped digits are written back for every command
    bar_cnt  = w.bar;
    beat_cnt = w.beat;
    div_cnt  = w.division;
    tick_cnt = w.tick;
    return w;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_cnt        = '0;
      beat_cnt       = '0;
      div_cnt        = '0;
      tick_cnt       = '0;
      tick_radix_reg = bbtpc_pkg::RST_TICKS_PER_DIV;
      div_radix_reg  = bbtpc_pkg::RST_DIVS_PER_BEAT;
      beat_radix_reg = bbtpc_pkg::RST_BEATS_PER_BAR;
      expected_positions.delete();
      err_count      = 0;
      results_seen   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      // outgoing position word against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_positions.size() == 0) begin
          err_count++;
          $display("%0t: position word 0x%0h with no prediction waiting", $time, out_data_i);
        end else begin
          want_word = expected_positions.pop_front();
          got_word  = out_data_i[WordW-1:0];
          check_field("pos_bar", want_word.bar, got_word.bar);
          check_field("pos_beat", 16'(want_word.beat), 16'(got_word.beat));
          check_field("pos_division", 16'(want_word.division), 16'(got_word.division));
          check_field("pos_tick", want_word.tick, got_word.tick);
          check_field("was_less", 16'(want_word.was_less), 16'(got_word.was_less));
          check_field("clamped", 16'(want_word.clamped), 16'(got_word.clamped));
          check_field("pad", 16'h0000, 16'(out_data_i[bbtpc_pkg::OutDataW-1:WordW]));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_positions.push_back(advance_position(in_cmd_i,
                                                      bbtpc_pkg::opd_t'(in_data_i)));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bbtpc_pkg::CFG_TICKS_PER_DIV: tick_radix_reg = cfg_wdata_i;
          bbtpc_pkg::CFG_DIVS_PER_BEAT: div_radix_reg  = cfg_wdata_i[7:0];
          bbtpc_pkg::CFG_BEATS_PER_BAR: beat_radix_reg = cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
      errors_o  <= err_count;
      pending_o <= expected_positions.size();
      results_o <= results_seen;
    end
  end

endmodule

[dv/tb_bar_beat_tick_position_counter.sv]
// Stimulus and verdict for the bar/beat/division/tick counter, checked by its scoreboard.
module tb_bar_beat_tick_position_counter;

  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned PhaseItems     = 108;
  localparam int unsigned PressureCycles = 160;
  localparam int unsigned DrainCycles    = 4;
  localparam logic [bbtpc_pkg::CmdW-1:0] CmdUnknown = 2'd3;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [bbtpc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [bbtpc_pkg::CmdW-1:0]     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bbtpc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                           cfg_we_i      = 1'b0;
  logic [bbtpc_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [bbtpc_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;

  int chk_errors;
  int chk_pending;
  int chk_results;
  int words_sent     = 0;
  int radix_settings = 1;
  int input_stalls   = 0;
  int cycle_count    = 0;
  bit pressure_go    = 1'b0;
  bit pressure_done  = 1'b0;

  // radices as last written, for well-formed operands
  logic [15:0] cur_tick_radix = bbtpc_pkg::RST_TICKS_PER_DIV;
  logic [7:0]  cur_div_radix  = bbtpc_pkg::RST_DIVS_PER_BEAT;
  logic [7:0]  cur_beat_radix = bbtpc_pkg::RST_BEATS_PER_BAR;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bar_beat_tick_position_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bbtpc_position_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .results_o   (chk_results)
  );

  // Cycle count for the watchdog, input stall count for the summary
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (s_axis_tvalid && !s_axis_tready) input_stalls <= input_stalls + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Watchdog expired after %0d cycles, %0d predictions open", cycle_count, chk_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned radix_of(logic [15:0] reg_value);
    return (reg_value == '0) ? 1 : int'(reg_value);
  endfunction

  function automatic bbtpc_pkg::opd_t mk_opd(logic [15:0] bar, logic [7:0] beat,
                                             logic [7:0] division, logic [15:0] tick);
    bbtpc_pkg::opd_t o;
    o.bar      = bar;
    o.beat     = beat;
    o.division = division;
    o.tick     = tick;
    return o;
  endfunction

  // Offer one operand word, wait for the handshake, then optionally idle
  task automatic offer(logic [bbtpc_pkg::CmdW-1:0] cmd, bbtpc_pkg::opd_t opd, bit burst);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= opd;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    gap = burst ? 0 : gap_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Block is idle once every prediction is met and the pipe has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chk_pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_radices(logic [15:0] tick_radix, logic [7:0] div_radix,
                               logic [7:0] beat_radix);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bbtpc_pkg::CFG_TICKS_PER_DIV;
    cfg_wdata_i <= tick_radix;
    @(posedge clk_i);
    cfg_idx_i   <= bbtpc_pkg::CFG_DIVS_PER_BEAT;
    cfg_wdata_i <= {8'h00, div_radix};
    @(posedge clk_i);
    cfg_idx_i   <= bbtpc_pkg::CFG_BEATS_PER_BAR;
    cfg_wdata_i <= {8'h00, beat_radix};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_tick_radix = tick_radix;
    cur_div_radix  = div_radix;
    cur_beat_radix = beat_radix;
    radix_settings++;
  endtask

  // Random words: mostly digits inside the radices, some noise and boundary digits
  task automatic run_random(int unsigned count);
    int unsigned rt, rd, rb, r;
    bit          burst;
    logic [bbtpc_pkg::CmdW-1:0] cmd;
    bbtpc_pkg::opd_t opd;
    burst = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      rt = radix_of(cur_tick_radix);
      rd = radix_of({8'h00, cur_div_radix});
      rb = radix_of({8'h00, cur_beat_radix});
      r  = $urandom_range(0, 99);
      if (r < 40) cmd = bbtpc_pkg::CMD_ADD;
      else if (r < 75) cmd = bbtpc_pkg::CMD_SUB;
      else if (r < 90) cmd = bbtpc_pkg::CMD_CMP;
      else cmd = CmdUnknown;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        opd = 48'({$urandom, $urandom});
      end else if (r < 14) begin
        // digits sitting right on the radix
        opd = mk_opd(16'($urandom_range(0, 3)), 8'(rb), 8'(rd), 16'(rt));
      end else begin
        opd.beat     = 8'($urandom_range(0, rb - 1));
        opd.division = 8'($urandom_range(0, rd - 1));
        opd.tick     = 16'($urandom_range(0, rt - 1));
        r = $urandom_range(0, 19);
        if (r == 0) opd.bar = 16'($urandom);
        else if (r < 4) opd.bar = 16'($urandom_range(0, 255));
        else opd.bar = 16'($urandom_range(0, 3));
      end
      offer(cmd, opd, burst);
    end
  endtask

  // Receiver: random hold-offs, long ready stretches, one long stall
  initial begin
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (pressure_go && !pressure_done) begin
        m_axis_tready <= 1'b0;
        repeat (PressureCycles) @(posedge clk_i);
        pressure_done = 1'b1;
      end else begin
        hold = gap_cycles();
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset radices (120, 4, 4)
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'd0, 8'd3, 8'd3, 16'd119), 1'b0);
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'd0, 8'd0, 8'd0, 16'd1), 1'b0);  // carry through all digits
    offer(bbtpc_pkg::CMD_CMP, mk_opd(16'd1, 8'd0, 8'd0, 16'd0), 1'b0);  // equal
    offer(bbtpc_pkg::CMD_CMP, mk_opd(16'd1, 8'd0, 8'd0, 16'd1), 1'b0);  // less by one tick
    offer(bbtpc_pkg::CMD_SUB, mk_opd(16'd1, 8'd0, 8'd0, 16'd0), 1'b0);  // subtract equal
    offer(bbtpc_pkg::CMD_SUB, mk_opd(16'd0, 8'd0, 8'd0, 16'd1), 1'b0);  // floor at zero
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'hFFFF, 8'd3, 8'd3, 16'd119), 1'b0);
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'd0, 8'd0, 8'd0, 16'd1), 1'b0);  // bar saturates
    offer(bbtpc_pkg::CMD_SUB, mk_opd(16'd0, 8'd0, 8'd0, 16'd1), 1'b0);  // borrow chain
    // operand digits over radix
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'd0, 8'hFF, 8'hFF, 16'hFFFF), 1'b0);
    offer(CmdUnknown, mk_opd(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b0);
    offer(bbtpc_pkg::CMD_SUB, mk_opd(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b0);
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'h5555, 8'h55, 8'h55, 16'h5555), 1'b0);
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'hAAAA, 8'hAA, 8'hAA, 16'hAAAA), 1'b0);
    offer(bbtpc_pkg::CMD_CMP, mk_opd(16'd0, 8'd0, 8'd0, 16'd0), 1'b0);
    offer(bbtpc_pkg::CMD_SUB, mk_opd(16'd0, 8'd0, 8'd0, 16'd0), 1'b0);
    offer(bbtpc_pkg::CMD_ADD, mk_opd(16'd0, 8'd0, 8'd0, 16'd0), 1'b0);

    // Random phases over several radix settings
    pressure_go = 1'b1;
    run_random(PhaseItems);
    write_radices(16'd0, 8'd0, 8'd0);          // zero radices act as one
    offer(bbtpc_pkg::CMD_CMP, mk_opd(16'd0, 8'd0, 8'd0, 16'd0), 1'b0);
    run_random(PhaseItems);
    write_radices(16'hFFFF, 8'hFF, 8'hFF);     // full scale
    run_random(PhaseItems);
    write_radices(16'd1, 8'd1, 8'd1);          // shrinks any stored digit
    offer(bbtpc_pkg::CMD_CMP, mk_opd(16'd0, 8'd0, 8'd0, 16'd0), 1'b0);
    run_random(PhaseItems);
    write_radices(16'd3, 8'd2, 8'd5);
    run_random(PhaseItems);
    write_radices(16'($urandom_range(1, 2000)), 8'($urandom_range(1, 16)),
                  8'($urandom_range(1, 16)));
    run_random(PhaseItems);
    write_radices(16'd40000, 8'd200, 8'd3);
    run_random(PhaseItems);
    write_radices(16'd0, 8'd7, 8'd0);
    run_random(PhaseItems);
    write_radices(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 255)));
    run_random(PhaseItems);
    write_radices(bbtpc_pkg::RST_TICKS_PER_DIV, bbtpc_pkg::RST_DIVS_PER_BEAT,
                  bbtpc_pkg::RST_BEATS_PER_BAR);
    run_random(PhaseItems);

    // Drain and verdict
    wait_idle();
    $display("Summary: %0d operand words, %0d position words, %0d radix settings incl. zero and full scale.",
             words_sent, chk_results, radix_settings);
    $display("Summary: output held off %0d cycles once, input stalled on %0d cycles.",
             PressureCycles, input_stalls);
    if (chk_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bbtpc_pkg.sv
rtl/core/bbtpc_step.sv
rtl/core/bar_beat_tick_position_counter.sv
dv/bbtpc_position_checker.sv
dv/tb_bar_beat_tick_position_counter.sv
